FILE: src/priority_message_queue_macros.svh
// Assertion macros used by the priority message queue RTL.
`ifndef PRIORITY_MESSAGE_QUEUE_MACROS_SVH
`define PRIORITY_MESSAGE_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising edge of clk, suspended while arst_n is low.
`define PMQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition that must never be seen on a rising edge of clk.
`define PMQ_ASSERT_NEVER(lbl, cond, msg) \
	`PMQ_ASSERT(lbl, !(cond), msg)
`else
`define PMQ_ASSERT(lbl, prop, msg)
`define PMQ_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: src/pmq_pkg.sv
// Types, codes and helper functions of the priority message queue.
package pmq_pkg;

	// Operation codes of a request.
	localparam logic [1:0] KIND_SEND  = 2'd0;
	localparam logic [1:0] KIND_RECV  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_MSG_BYTES = 2'd1;
	localparam logic [1:0] REG_PRIO_EN  = 2'd2;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int OCC_W   = 5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] payload;
		logic [3:0]  length;
		logic [7:0]  priority_req;
		logic [3:0]  room;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [63:0]      out_payload;
		logic [3:0]       out_length;
		logic [7:0]       out_priority;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

	// One stored message.
	typedef struct packed {
		logic [63:0] payload;
		logic [3:0]  length;
		logic [7:0]  prio;
	} entry_t;

	// Configuration register values.
	typedef struct packed {
		logic [4:0] capacity;
		logic [3:0] msg_bytes;
		logic       prio_en;
	} cfg_t;

	// Mask that keeps the low len bytes of a 64-bit word.
	function automatic logic [63:0] byte_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			m[8*b +: 8] = (4'(b) < len) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

FILE: src/pmq_store.sv
// Message memory: one write port, one read port, registered read data.
module pmq_store
	import pmq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  entry_t                   wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output entry_t                   rdata
);

	entry_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: src/pmq_ctrl.sv
// Sequencer of the queue: checks requests, walks the memory and builds results.
module pmq_ctrl
	import pmq_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int MSG_BYTES = 8,
	parameter int PRIO_MAX  = 31
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  req_t                     req,
	input  cfg_t                     cfg,
	output logic                     done_valid,
	output rsp_t                     done,
	input  logic                     done_take,
	output logic                     mem_we,
	output logic [$clog2(DEPTH)-1:0] mem_waddr,
	output entry_t                   mem_wdata,
	output logic [$clog2(DEPTH)-1:0] mem_raddr,
	input  entry_t                   mem_rdata
);

	localparam int SW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;

	typedef enum logic [2:0] {S_IDLE, S_RD_HEAD, S_SHIFT, S_INS, S_DONE} state_t;

	state_t          state_q;
	logic [SW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	entry_t          item_q;
	logic [3:0]      room_q;
	rsp_t            res_q;

	logic [CMPW-1:0] cap_eff;
	logic [3:0]      msg_eff;
	logic            bad_send;
	logic            full;
	logic            prio_off;
	logic            needs_shift;
	entry_t          new_entry;
	logic            accept;
	logic            move;

	// Physical slot of the entry at a given distance from the head.
	function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] head,
			input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(off);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[SW-1:0];
	endfunction

	// Effective limits, with out-of-range register values clamped.
	always_comb begin
		if (cfg.capacity == 5'd0) begin
			cap_eff = CMPW'(1);
		end else if (CMPW'(cfg.capacity) > CMPW'(DEPTH)) begin
			cap_eff = CMPW'(DEPTH);
		end else begin
			cap_eff = CMPW'(cfg.capacity);
		end
		if (cfg.msg_bytes == 4'd0) begin
			msg_eff = 4'd1;
		end else if (cfg.msg_bytes > 4'(MSG_BYTES)) begin
			msg_eff = 4'(MSG_BYTES);
		end else begin
			msg_eff = cfg.msg_bytes;
		end
	end

	// Send checks and the entry that a send would store.
	assign bad_send    = (req.priority_req > 8'(PRIO_MAX)) || (req.length > msg_eff);
	assign full        = CMPW'(count_q) >= cap_eff;
	assign prio_off    = !cfg.prio_en && (req.priority_req != 8'd0);
	assign needs_shift = cfg.prio_en && (req.priority_req != 8'd0) && (count_q != '0);
	assign new_entry   = '{payload: req.payload & byte_mask(req.length),
		length: req.length, prio: cfg.prio_en ? req.priority_req : 8'd0};

	assign accept     = req_valid && (state_q == S_IDLE);
	assign req_stall  = (state_q != S_IDLE);
	assign done_valid = (state_q == S_DONE);
	assign done       = res_q;

	// A stored entry of lower priority moves one slot towards the tail.
	assign move = mem_rdata.prio < item_q.prio;

	// Memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_of(head_q, count_q);
		mem_wdata = new_entry;
		mem_raddr = head_q;
		case (state_q)
			S_IDLE: begin
				if (accept && req.kind == KIND_SEND && !bad_send && !full && !prio_off
						&& !needs_shift) begin
					mem_we = 1'b1;
				end
				if (req.kind == KIND_SEND && count_q != '0) begin
					mem_raddr = slot_of(head_q, count_q - CW'(1));
				end
			end
			S_SHIFT: begin
				mem_we    = 1'b1;
				mem_waddr = slot_of(head_q, idx_q);
				mem_wdata = move ? mem_rdata : item_q;
				if (idx_q > CW'(1)) begin
					mem_raddr = slot_of(head_q, idx_q - CW'(2));
				end
			end
			S_INS: begin
				mem_we    = 1'b1;
				mem_waddr = head_q;
				mem_wdata = item_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state, queue pointers and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			item_q  <= '0;
			room_q  <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q             <= new_entry;
						room_q             <= req.room;
						res_q.out_payload  <= '0;
						res_q.out_length   <= '0;
						res_q.out_priority <= '0;
						case (req.kind)
							KIND_SEND: begin
								if (bad_send) begin
									res_q.status    <= ST_INVALID;
									res_q.occupancy <= OCC_W'(count_q);
									state_q         <= S_DONE;
								end else if (full) begin
									res_q.status    <= ST_FULL;
									res_q.occupancy <= OCC_W'(count_q);
									state_q         <= S_DONE;
								end else if (prio_off) begin
									res_q.status    <= ST_INVALID;
									res_q.occupancy <= OCC_W'(count_q);
									state_q         <= S_DONE;
								end else if (needs_shift) begin
									// The count is settled once the entry is placed.
									res_q.status    <= ST_OK;
									res_q.occupancy <= OCC_W'(count_q);
									idx_q           <= count_q;
									state_q         <= S_SHIFT;
								end else begin
									res_q.status    <= ST_OK;
									res_q.occupancy <= OCC_W'(count_q + CW'(1));
									count_q         <= count_q + CW'(1);
									state_q         <= S_DONE;
								end
							end
							KIND_RECV: begin
								res_q.occupancy <= OCC_W'(count_q);
								if (count_q == '0) begin
									res_q.status <= ST_EMPTY;
									state_q      <= S_DONE;
								end else begin
									res_q.status <= ST_OK;
									state_q      <= S_RD_HEAD;
								end
							end
							KIND_QUERY: begin
								res_q.status    <= ST_OK;
								res_q.occupancy <= OCC_W'(count_q);
								state_q         <= S_DONE;
							end
							default: begin
								res_q.status    <= ST_INVALID;
								res_q.occupancy <= OCC_W'(count_q);
								state_q         <= S_DONE;
							end
						endcase
					end
				end
				S_RD_HEAD: begin
					res_q.out_length <= mem_rdata.length;
					if (mem_rdata.length > room_q) begin
						res_q.status <= ST_OVERFLOW;
					end else begin
						res_q.status       <= ST_OK;
						res_q.out_payload  <= mem_rdata.payload & byte_mask(mem_rdata.length);
						res_q.out_priority <= cfg.prio_en ? mem_rdata.prio : 8'd0;
						res_q.occupancy    <= OCC_W'(count_q - CW'(1));
						head_q             <= slot_of(head_q, CW'(1));
						count_q            <= count_q - CW'(1);
					end
					state_q <= S_DONE;
				end
				S_SHIFT: begin
					if (move) begin
						idx_q <= idx_q - CW'(1);
						if (idx_q == CW'(1)) begin
							state_q <= S_INS;
						end
					end else begin
						count_q         <= count_q + CW'(1);
						res_q.occupancy <= OCC_W'(count_q + CW'(1));
						state_q         <= S_DONE;
					end
				end
				S_INS: begin
					count_q         <= count_q + CW'(1);
					res_q.occupancy <= OCC_W'(count_q + CW'(1));
					state_q         <= S_DONE;
				end
				S_DONE: begin
					if (done_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/priority_message_queue.sv
// Priority message queue: one request at a time, one result per request.
// Query, rejected send and empty receive: the result is set at accept, then moved to the output register.
// Receive: the head is read from the memory first. Send appended at the tail: written and answered at accept.
// Prioritised send: stored entries of lower priority move one at a time through the memory, then the new one is placed.
// A new request is taken the cycle after the previous result enters the output register.
// Reset empties the queue at once (no clearing pass); registers return to 16, 8 and 1.
`include "priority_message_queue_macros.svh"
module priority_message_queue
	import pmq_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int MSG_BYTES = 8,
	parameter int PRIO_MAX  = 31
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int SW = $clog2(DEPTH);

	cfg_t          cfg_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	logic          done_valid;
	rsp_t          done;
	logic          done_take;
	logic          mem_we;
	logic [SW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic [SW-1:0] mem_raddr;
	entry_t        mem_rdata;

	// Configuration registers, written on the access phase of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity  <= 5'd16;
			cfg_q.msg_bytes <= 4'd8;
			cfg_q.prio_en   <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_CAPACITY: cfg_q.capacity <= pwdata[4:0];
				REG_MSG_BYTES: cfg_q.msg_bytes <= pwdata[3:0];
				REG_PRIO_EN: cfg_q.prio_en <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[3:2])
			REG_CAPACITY: prdata = PDATA_W'(cfg_q.capacity);
			REG_MSG_BYTES: prdata = PDATA_W'(cfg_q.msg_bytes);
			REG_PRIO_EN: prdata = PDATA_W'(cfg_q.prio_en);
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// Output register: takes a finished result whenever it is empty or being drained.
	assign done_take = done_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (done_take) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= done;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	pmq_ctrl #(
		.DEPTH     (DEPTH),
		.MSG_BYTES (MSG_BYTES),
		.PRIO_MAX  (PRIO_MAX)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.cfg        (cfg_q),
		.done_valid (done_valid),
		.done       (done),
		.done_take  (done_take),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	pmq_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Only one request is in flight: the cycle after an accept the input is stalled.
	`PMQ_ASSERT(a_single_request, req_valid && !req_stall |=> req_stall, "second request taken")
	// An empty report always comes with an empty queue.
	`PMQ_ASSERT_NEVER(a_empty_occ, rsp_valid && rsp.status == ST_EMPTY && rsp.occupancy != '0, "empty")
	// An overflow report carries the length of a real message.
	`PMQ_ASSERT_NEVER(a_overflow_len, rsp_valid && rsp.status == ST_OVERFLOW && rsp.out_length == 4'd0, "overflow")

endmodule

FILE: sim/pmq_tb_pkg.sv
// Scoreboard and behavioural predictor used by the priority message queue testbench.
package pmq_tb_pkg;
	import pmq_pkg::*;

	localparam int QUEUE_DEPTH   = 16;
	localparam int MAX_MSG_BYTES = 8;
	localparam int PRIO_LIMIT    = 31;

	// The fourth operation code has no meaning and must be refused.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	class queue_scoreboard;
		cfg_t   cfg;
		entry_t held[$];
		rsp_t   outstanding[$];
		int     errors;
		int     checked;
		int     outcome_count[5];

		function new();
			cfg.capacity = 5'd16;
			cfg.msg_bytes = 4'd8;
			cfg.prio_en = 1'b1;
			errors = 0;
			checked = 0;
			foreach (outcome_count[i]) outcome_count[i] = 0;
		endfunction

		// Mirror a register write made on the configuration port.
		function void set_config(logic [1:0] idx, logic [31:0] value);
			case (idx)
			REG_CAPACITY: cfg.capacity = value[4:0];
			REG_MSG_BYTES: cfg.msg_bytes = value[3:0];
			REG_PRIO_EN: cfg.prio_en = value[0];
			default: ;
			endcase
		endfunction

		// Work out the result of one request and update the held messages.
		function rsp_t predict_outcome(req_t r);
			rsp_t   o;
			entry_t e;
			int     cap;
			int     size_cap;
			int     pos;
			o = '0;
			cap = (cfg.capacity == 0) ? 1 :
				((cfg.capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(cfg.capacity));
			size_cap = (cfg.msg_bytes == 0) ? 1 :
				((cfg.msg_bytes > MAX_MSG_BYTES) ? MAX_MSG_BYTES : int'(cfg.msg_bytes));
			case (r.kind)
			KIND_SEND: begin
				// Bad arguments are refused before the full check, which comes
				// before the check for a priority while priorities are off.
				if (r.priority_req > PRIO_LIMIT || r.length > size_cap) begin
					o.status = ST_INVALID;
				end else if (held.size() >= cap) begin
					o.status = ST_FULL;
				end else if (!cfg.prio_en && r.priority_req != 0) begin
					o.status = ST_INVALID;
				end else begin
					e.payload = (r.length >= 8) ? r.payload :
						(r.payload & ((64'd1 << (8 * r.length)) - 64'd1));
					e.length = r.length;
					e.prio = cfg.prio_en ? r.priority_req : 8'd0;
					pos = held.size();
					// A prioritised message goes before the first lower priority.
					if (cfg.prio_en && r.priority_req != 0) begin
						for (int i = 0; i < held.size(); i++) begin
							if (held[i].prio < r.priority_req) begin
								pos = i;
								break;
							end
						end
					end
					held.insert(pos, e);
					o.status = ST_OK;
				end
			end
			KIND_RECV: begin
				if (held.size() == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.out_length = held[0].length;
					// Too little room: the length is reported and the head stays.
					if (held[0].length > r.room) begin
						o.status = ST_OVERFLOW;
					end else begin
						o.status = ST_OK;
						o.out_payload = held[0].payload;
						o.out_priority = cfg.prio_en ? held[0].prio : 8'd0;
						void'(held.pop_front());
					end
				end
			end
			KIND_QUERY: o.status = ST_OK;
			default: o.status = ST_INVALID;
			endcase
			o.occupancy = OCC_W'(held.size());
			return o;
		endfunction

		// Record an accepted request and queue the result it must produce.
		function void note_request(req_t r);
			rsp_t want;
			want = predict_outcome(r);
			outstanding.push_back(want);
			outcome_count[want.status]++;
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// Compare one accepted result with the oldest outstanding one.
		task check_result(rsp_t got);
			rsp_t want;
			if (outstanding.size() == 0) begin
				report_mismatch($sformatf("result with none outstanding, status %0d",
					got.status));
				return;
			end
			want = outstanding.pop_front();
			checked++;
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, wanted %0d", got.status,
					want.status));
			if (got.out_payload !== want.out_payload)
				report_mismatch($sformatf("out_payload %h, wanted %h", got.out_payload,
					want.out_payload));
			if (got.out_length !== want.out_length)
				report_mismatch($sformatf("out_length %0d, wanted %0d", got.out_length,
					want.out_length));
			if (got.out_priority !== want.out_priority)
				report_mismatch($sformatf("out_priority %0d, wanted %0d",
					got.out_priority, want.out_priority));
			if (got.occupancy !== want.occupancy)
				report_mismatch($sformatf("occupancy %0d, wanted %0d", got.occupancy,
					want.occupancy));
		endtask
	endclass

endpackage

FILE: sim/tb_top.sv
// Top-level testbench of the priority message queue: stimulus, handshakes and watchdog.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pmq_pkg::*;
	import pmq_tb_pkg::*;

	localparam int PHASES          = 10;
	localparam int PHASE_REQUESTS  = 68;
	localparam int WATCHDOG_LIMIT  = 4000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	req_t               req = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_t               rsp;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	queue_scoreboard sb;
	int              offered = 0;
	bit              squeeze_rsp = 1'b0;

	// Register settings per phase, the extremes and out-of-range codes among them.
	int cap_plan[PHASES] = '{16, 1, 0, 31, 17, 4, 16, 2, 8, 16};
	int size_plan[PHASES] = '{8, 1, 0, 15, 9, 3, 8, 5, 8, 2};
	int prio_plan[PHASES] = '{1, 1, 0, 1, 0, 1, 0, 1, 1, 1};

	priority_message_queue #(
		.DEPTH(QUEUE_DEPTH),
		.MSG_BYTES(MAX_MSG_BYTES),
		.PRIO_MAX(PRIO_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// Idle length: mostly short, now and then a long one.
	function automatic int pick_gap();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(8, 40);
	endfunction

	function automatic req_t make_req(logic [1:0] kind, logic [63:0] payload,
		logic [3:0] length, logic [7:0] prio, logic [3:0] room);
		req_t r;
		r.kind = kind;
		r.payload = payload;
		r.length = length;
		r.priority_req = prio;
		r.room = room;
		return r;
	endfunction

	// Random request: mostly well-formed sends and receives, some wild fields.
	function automatic req_t gen_request(int send_pct);
		req_t r;
		int   pick;
		int   size_cap;
		size_cap = (sb.cfg.msg_bytes == 0) ? 1 :
			((sb.cfg.msg_bytes > MAX_MSG_BYTES) ? MAX_MSG_BYTES : int'(sb.cfg.msg_bytes));
		r.payload = {$urandom, $urandom};
		r.length = 4'($urandom_range(0, 15));
		r.priority_req = 8'($urandom_range(0, 255));
		r.room = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (pick < send_pct) begin
			r.kind = KIND_SEND;
			if ($urandom_range(0, 9) != 0)
				r.length = 4'($urandom_range(0, size_cap));
			if ($urandom_range(0, 9) != 0)
				r.priority_req = (!sb.cfg.prio_en || $urandom_range(0, 3) == 0) ? 8'd0 :
					8'($urandom_range(1, PRIO_LIMIT));
		end else if (pick < 90) begin
			r.kind = KIND_RECV;
			if ($urandom_range(0, 4) != 0)
				r.room = 4'($urandom_range(8, 15));
		end else if (pick < 97) begin
			r.kind = KIND_QUERY;
		end else begin
			r.kind = KIND_UNUSED;
		end
		return r;
	endfunction

	// Offer one request, after an optional gap, and hold it until it is taken.
	task automatic send_request(input req_t r);
		int gap;
		gap = ((offered % 96) < 24) ? 0 : pick_gap();
		offered++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
	endtask

	task automatic wait_drained();
		while (sb.outstanding.size() != 0) @(posedge clk);
	endtask

	// Setup and access cycle on the configuration port, then back to idle.
	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_config(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: take results, stall at random, and hold off for long on request.
	initial begin
		int stall_run;
		int flow_run;
		int hold_cycles;
		stall_run = 0;
		flow_run = 0;
		hold_cycles = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				sb.check_result(rsp);
			if (squeeze_rsp) begin
				squeeze_rsp = 1'b0;
				hold_cycles = 80;
			end
			if (hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				hold_cycles--;
			end else if (stall_run > 0) begin
				rsp_stall <= 1'b1;
				stall_run--;
			end else if (flow_run > 0) begin
				rsp_stall <= 1'b0;
				flow_run--;
			end else begin
				rsp_stall <= 1'b0;
				flow_run = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) :
					$urandom_range(1, 8);
				stall_run = pick_gap();
			end
		end
	end

	// Watchdog: end the run if nothing moves on any port for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
		$display("priority_message_queue regression: fail");
		$finish;
	end

	// Main sequence: reset, directed requests, then randomised phases.
	initial begin
		int send_pct;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue, the unused operation, sends at the argument limits and sends refused for bad arguments.
		send_request(make_req(KIND_QUERY, {$urandom, $urandom}, 4'd0, 8'd0, 4'd0));
		send_request(make_req(KIND_RECV, {$urandom, $urandom}, 4'd0, 8'd0, 4'd8));
		send_request(make_req(KIND_UNUSED, {$urandom, $urandom}, 4'd3, 8'd7, 4'd8));
		send_request(make_req(KIND_SEND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 8'd0, 4'd0));
		send_request(make_req(KIND_SEND, {$urandom, $urandom}, 4'd0, 8'd31, 4'd0));
		send_request(make_req(KIND_SEND, {$urandom, $urandom}, 4'd3, 8'd32, 4'd0));
		send_request(make_req(KIND_SEND, {$urandom, $urandom}, 4'd2, 8'd255, 4'd0));
		send_request(make_req(KIND_SEND, {$urandom, $urandom}, 4'd9, 8'd1, 4'd0));
		send_request(make_req(KIND_SEND, {$urandom, $urandom}, 4'd15, 8'd0, 4'd15));
		// Equal priorities keep their arrival order; higher ones jump ahead.
		send_request(make_req(KIND_SEND, {$urandom, $urandom}, 4'd3, 8'd5, 4'd0));
		send_request(make_req(KIND_SEND, {$urandom, $urandom}, 4'd4, 8'd5, 4'd0));
		send_request(make_req(KIND_SEND, {$urandom, $urandom}, 4'd1, 8'd31, 4'd0));
		send_request(make_req(KIND_SEND, {$urandom, $urandom}, 4'd7, 8'd1, 4'd0));
		// Zero-length head with no room, then a head that overflows and is kept.
		send_request(make_req(KIND_RECV, {$urandom, $urandom}, 4'd0, 8'd0, 4'd0));
		send_request(make_req(KIND_RECV, {$urandom, $urandom}, 4'd0, 8'd0, 4'd0));
		send_request(make_req(KIND_RECV, {$urandom, $urandom}, 4'd0, 8'd0, 4'd15));
		send_request(make_req(KIND_QUERY, {$urandom, $urandom}, 4'd0, 8'd0, 4'd0));
		req_valid <= 1'b0;

		// Capacity lowered below the count, with priorities switched off.
		wait_drained();
		write_register(REG_CAPACITY, 32'd2);
		write_register(REG_PRIO_EN, 32'd0);
		send_request(make_req(KIND_SEND, {$urandom, $urandom}, 4'd2, 8'd0, 4'd0));
		send_request(make_req(KIND_RECV, {$urandom, $urandom}, 4'd0, 8'd0, 4'd15));
		send_request(make_req(KIND_RECV, {$urandom, $urandom}, 4'd0, 8'd0, 4'd2));
		send_request(make_req(KIND_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 8'hFF, 4'hF));
		req_valid <= 1'b0;

		// Random phases, each under its own register setting.
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			write_register(REG_CAPACITY, 32'(cap_plan[p]));
			write_register(REG_MSG_BYTES, 32'(size_plan[p]));
			write_register(REG_PRIO_EN, 32'(prio_plan[p]));
			send_pct = $urandom_range(35, 65);
			// In two phases the result side holds off so the block backs up.
			if (p == 0 || p == 6) begin
				send_pct = 70;
				squeeze_rsp = 1'b1;
			end
			for (int i = 0; i < PHASE_REQUESTS; i++)
				send_request(gen_request(send_pct));
			req_valid <= 1'b0;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.outstanding.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived",
				sb.outstanding.size()));

		$display("Drove %0d requests through %0d register settings; %0d results checked.",
			offered, PHASES + 2, sb.checked);
		$display("Outcomes: ok %0d, invalid %0d, full %0d, empty %0d, overflow %0d.",
			sb.outcome_count[ST_OK], sb.outcome_count[ST_INVALID],
			sb.outcome_count[ST_FULL], sb.outcome_count[ST_EMPTY],
			sb.outcome_count[ST_OVERFLOW]);
		if (sb.errors == 0) begin
			$display("priority_message_queue regression: pass");
		end else begin
			$display("priority_message_queue regression: fail");
		end
		$finish;
	end

endmodule
